### hw/rtl/sdf_glyph_pixel_renderer_assert.svh
// Assertion macros for the glyph renderer.
`ifndef SDF_GLYPH_PIXEL_RENDERER_ASSERT_SVH
`define SDF_GLYPH_PIXEL_RENDERER_ASSERT_SVH
`ifndef SYNTHESIS
`define SGR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SGR_ASSERT(label, clk, rst_n, prop)
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/sgr_pkg.sv
package sgr_pkg;
  localparam int AtlasTexels = 65536;
  localparam int AddrW = $clog2(AtlasTexels);

  localparam logic [2:0] RegAtlasWidth  = 3'd0;
  localparam logic [2:0] RegAtlasHeight = 3'd1;
  localparam logic [2:0] RegGlyphX      = 3'd2;
  localparam logic [2:0] RegGlyphY      = 3'd3;
  localparam logic [2:0] RegInvScale    = 3'd4;
  localparam logic [2:0] RegOutHeight   = 3'd5;
  localparam logic [2:0] RegSkew        = 3'd6;
  localparam logic [2:0] RegBoldBias    = 3'd7;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpRender = 1'b1;

  // one sample request for the texel fetch unit
  typedef struct packed {
    logic        valid;
    logic        oob;
    logic [AddrW-1:0] addr;
    logic        last;
  } fetch_req_t;
endpackage

### hw/rtl/sgr_atlas_mem.sv
module sgr_atlas_mem import sgr_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem [AtlasTexels];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

### hw/rtl/sdf_glyph_pixel_renderer.sv
// SDF glyph pixel renderer.
// Input channel (in_valid_i/in_ready_o): operation 0 writes texel_value at
// texel_address into the atlas RAM and yields no beat; operation 1 renders
// pixel (pixel_x, pixel_y) and yields one alpha beat.
// Output channel (out_valid_o/out_ready_i) carries alpha.
// Config port: cfg_we_i, cfg_index_i, cfg_data_i; write only while idle.
// A render beat goes through a two-stage coordinate pipe (skew multiply,
// scale multiply), an index clamp stage, then four atlas reads on the single
// RAM read port, one per cycle unless the blend side holds the last read,
// then a blend/alpha pipe ending in the output register behind out_valid_o.
// Each render holds the single read port for its four reads; a write that
// follows a render waits until that render has issued its four atlas reads.
// The front stages accept a new beat while the back end works.
// Reset restores the register defaults; atlas contents are undefined until
// written. If out_ready_i is low the result sits in the output register and
// the pipe stalls behind it once its stages fill.
module sdf_glyph_pixel_renderer import sgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] texel_address_i,
  input  logic [7:0]  texel_value_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  alpha_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
`include "sdf_glyph_pixel_renderer_assert.svh"

  logic [8:0]  width_q, height_q;
  logic [7:0]  gx_q, gy_q, oh_q;
  logic [23:0] inv_q;
  logic [15:0] skew_q, bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd256; height_q <= 9'd256; gx_q <= '0; gy_q <= '0;
      inv_q <= 24'd65536; oh_q <= '0; skew_q <= '0; bias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegAtlasWidth:  width_q  <= cfg_data_i[8:0];
        RegAtlasHeight: height_q <= cfg_data_i[8:0];
        RegGlyphX:      gx_q     <= cfg_data_i[7:0];
        RegGlyphY:      gy_q     <= cfg_data_i[7:0];
        RegInvScale:    inv_q    <= cfg_data_i;
        RegOutHeight:   oh_q     <= cfg_data_i[7:0];
        RegSkew:        skew_q   <= cfg_data_i[15:0];
        RegBoldBias:    bias_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [8:0] w_eff, h_eff;
  assign w_eff = (width_q == '0) ? 9'd1 : width_q;
  assign h_eff = (height_q == '0) ? 9'd1 : height_q;

  // ---------------- stage 1: skew multiply
  logic        s1_v_q;
  logic [8:0]  s1_fy_q;
  logic        s2_v_q;
  logic        s2_ready, s1_ready;

  logic        in_fire, wr_fire, rd_fire;
  assign in_fire = in_valid_i && in_ready_o;
  assign wr_fire = in_fire && (operation_i == OpWrite);
  assign rd_fire = in_fire && (operation_i == OpRender);

  logic signed [8:0]  dy;
  logic signed [25:0] skprod;
  logic signed [25:0] sx_full;
  assign dy = $signed({1'b0, pixel_y_i}) - $signed({1'b0, oh_q});
  assign skprod = $signed(skew_q) * dy;
  assign sx_full = $signed({16'd0, pixel_x_i, 2'b10}) <<< 10;

  logic signed [26:0] sx_sum;
  assign sx_sum = 27'(sx_full) + 27'(skprod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= rd_fire;
    end
  end
  logic signed [26:0] s1_sxw_q;
  always_ff @(posedge clk_i) begin
    if (s1_ready && rd_fire) begin
      s1_sxw_q <= sx_sum;
      s1_fy_q  <= {pixel_y_i, 1'b1};
    end
  end
  assign s1_ready = !s1_v_q || s2_ready;

  // ---------------- stage 2: scale multiply, coordinates
  logic signed [51:0] uprod;
  logic        [32:0] vprod;
  assign uprod = s1_sxw_q * $signed({1'b0, inv_q});
  assign vprod = s1_fy_q * inv_q;

  logic signed [31:0] s2_u_q;  // Q.8
  logic signed [31:0] s2_v8_q;
  logic fetch_ready;
  assign s2_ready = !s2_v_q || fetch_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_u_q  <= $signed({24'd0, gx_q}) * 256 + 32'(uprod >>> 20);
      s2_v8_q <= $signed({24'd0, gy_q}) * 256 + $signed({8'd0, vprod[32:9]});
    end
  end

  // ---------------- stage 3: index clamp
  logic signed [23:0] iu, iv;
  assign iu = s2_u_q[31:8];
  assign iv = s2_v8_q[31:8];

  function automatic logic [8:0] clampi(input logic signed [23:0] i,
                                        input logic [8:0] lim);
    logic signed [23:0] l;
    l = $signed({15'd0, lim});
    if (i < 0) return 9'd0;
    if (i >= l) return 9'(l - 24'sd1);
    return i[8:0];
  endfunction

  logic       s3_v_q;
  logic [8:0] c0_q, c1_q, r0_q, r1_q;
  logic [7:0] fu3_q, fv3_q;
  logic       s3_ready;
  assign fetch_ready = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_ready) begin
      s3_v_q <= s2_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      c0_q <= clampi(iu, w_eff);
      c1_q <= clampi(iu + 24'sd1, w_eff);
      r0_q <= clampi(iv, h_eff);
      r1_q <= clampi(iv + 24'sd1, h_eff);
      fu3_q <= s2_u_q[7:0];
      fv3_q <= s2_v8_q[7:0];
    end
  end

  // ---------------- stage 4: four reads through one RAM port
  logic [1:0]  rd_cnt_q;
  logic        busy_q;
  logic        bl_ready;
  fetch_req_t  req_q;
  logic [7:0]  fu4_q, fv4_q;
  logic [7:0]  fu5_q, fv5_q;
  logic        load;
  logic        rd_pending;

  // a write must not overtake a render that has not read the atlas yet
  assign rd_pending = s1_v_q || s2_v_q || s3_v_q || busy_q;
  assign in_ready_o = s1_ready && !((operation_i == OpWrite) && rd_pending);

  assign load = s3_v_q && (!busy_q || (rd_cnt_q == 2'd3 && bl_ready));
  assign s3_ready = !s3_v_q || load;

  logic [8:0] c0h_q, c1h_q, r0h_q, r1h_q;
  // hold indices for the running fetch separately so stage 3 can refill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rd_cnt_q <= '0;
    end else if (busy_q && !(rd_cnt_q == 2'd3 && !bl_ready)) begin
      if (rd_cnt_q == 2'd3) begin
        busy_q <= load;
        rd_cnt_q <= '0;
      end else begin
        rd_cnt_q <= rd_cnt_q + 2'd1;
      end
    end else if (!busy_q && load) begin
      busy_q <= 1'b1;
      rd_cnt_q <= '0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (load) begin
      c0h_q <= c0_q; c1h_q <= c1_q; r0h_q <= r0_q; r1h_q <= r1_q;
      fu4_q <= fu3_q; fv4_q <= fv3_q;
    end
  end

  logic [8:0]  colh, rowh;
  logic [17:0] rawh;
  assign colh = rd_cnt_q[0] ? c1h_q : c0h_q;
  assign rowh = rd_cnt_q[1] ? r1h_q : r0h_q;
  assign rawh = rowh * w_eff + 18'(colh);

  logic step;
  assign step = busy_q && !(rd_cnt_q == 2'd3 && !bl_ready);

  // fractions travel with the last read, the hold registers may refill then
  always_ff @(posedge clk_i) begin
    if (step && rd_cnt_q == 2'd3) begin
      fu5_q <= fu4_q; fv5_q <= fv4_q;
    end
  end

  logic [7:0] rdata;
  sgr_atlas_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_fire && (17'(texel_address_i) < 17'(AtlasTexels))),
    .waddr_i (texel_address_i[AddrW-1:0]),
    .wdata_i (texel_value_i),
    .raddr_i (rawh[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q.valid <= step;
      req_q.oob   <= rawh >= 18'(AtlasTexels);
      req_q.addr  <= rawh[AddrW-1:0];
      req_q.last  <= rd_cnt_q == 2'd3;
    end
  end

  // ---------------- collect texels
  logic [7:0] p00_q, p10_q, p01_q;
  logic [7:0] tex;
  logic       bl_v_q;
  logic [7:0] p00b_q, p10b_q, p01b_q, p11b_q, fub_q, fvb_q;
  logic [1:0] cc_q;
  logic       out_stall;
  assign tex = req_q.oob ? 8'd0 : rdata;
  assign bl_ready = !bl_v_q || !out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= '0;
      bl_v_q <= 1'b0;
    end else begin
      if (req_q.valid) cc_q <= cc_q + 2'd1;
      if (bl_ready) bl_v_q <= req_q.valid && req_q.last;
    end
  end
  always_ff @(posedge clk_i) begin
    if (req_q.valid) begin
      unique case (cc_q)
        2'd0: p00_q <= tex;
        2'd1: p10_q <= tex;
        2'd2: p01_q <= tex;
        default: ;
      endcase
    end
    if (bl_ready && req_q.valid && req_q.last) begin
      p00b_q <= p00_q; p10b_q <= p10_q; p01b_q <= p01_q; p11b_q <= tex;
      fub_q <= fu5_q; fvb_q <= fv5_q;
    end
  end

  // ---------------- blend stage A: horizontal lerps
  logic signed [17:0] a0, a1;
  assign a0 = $signed({10'd0, p00b_q} <<< 8)
            + $signed({1'b0, fub_q}) * ($signed({1'b0, p10b_q}) - $signed({1'b0, p00b_q}));
  assign a1 = $signed({10'd0, p01b_q} <<< 8)
            + $signed({1'b0, fub_q}) * ($signed({1'b0, p11b_q}) - $signed({1'b0, p01b_q}));

  logic               ba_v_q;
  logic signed [17:0] a0_q, a1_q;
  logic [7:0]         fva_q;
  logic               ba_ready;
  assign out_stall = bl_v_q && !ba_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ba_v_q <= 1'b0;
    else if (ba_ready) ba_v_q <= bl_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (ba_ready && bl_v_q) begin
      a0_q <= a0; a1_q <= a1; fva_q <= fvb_q;
    end
  end

  // ---------------- blend stage B: vertical lerp and threshold
  logic signed [27:0] a16, dist16, t;
  assign a16 = (28'(a0_q) <<< 8) + $signed({1'b0, fva_q}) * 28'(a1_q - a0_q);
  assign dist16 = a16 - 28'sd8388608 - (28'($signed(bias_q)) <<< 8);
  assign t = dist16 + 28'sd1048576;

  logic               bb_v_q;
  logic signed [27:0] t_q;
  logic               bb_ready;
  assign ba_ready = !ba_v_q || bb_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bb_v_q <= 1'b0;
    else if (bb_ready) bb_v_q <= ba_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (bb_ready && ba_v_q) t_q <= t;
  end

  // ---------------- alpha scale and output register
  logic [35:0] al;
  logic [7:0]  alpha_d, alpha_q;
  logic        ov_q;
  assign al = ({9'd0, t_q[26:0]} * 36'd255) >> 21;
  always_comb begin
    if (t_q <= 0) alpha_d = 8'd0;
    else if (al > 36'd255) alpha_d = 8'd255;
    else alpha_d = al[7:0];
  end
  assign bb_ready = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (bb_ready) ov_q <= bb_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (bb_ready && bb_v_q) alpha_q <= alpha_d;
  end
  assign out_valid_o = ov_q;
  assign alpha_o = alpha_q;

  `SGR_ASSERT(a_cnt_align, clk_i, rst_ni, (req_q.valid && req_q.last) |-> (cc_q == 2'd3))
  `SGR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, (ov_q && !out_ready_i), (ov_q && $stable(alpha_q)))
  `SGR_ASSERT(a_fetch_cnt, clk_i, rst_ni, (!busy_q) |-> (rd_cnt_q == 2'd0))
  `SGR_ASSERT_NEXT(a_stall_fetch, clk_i, rst_ni, (busy_q && rd_cnt_q == 2'd3 && !bl_ready), (busy_q && rd_cnt_q == 2'd3))
endmodule
